/* design/mrfde_pkg.sv */
// Shared types and constants of the MRF depth energy accumulator.
// Used by every module of the block; no dependencies of its own.
package mrfde_pkg;

  localparam int DEPTH_W    = 16;
  localparam int WEIGHT_W   = 16;
  localparam int SIZE_W     = 11;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SQ_W       = 2 * DEPTH_W;
  localparam int PROD_W     = WEIGHT_W + SQ_W;
  localparam int TERM_W     = PROD_W - 8 + 1;
  localparam int ENERGY_W   = 63;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_WEIGHT  = 2'd2;

  typedef struct packed {
    logic [DEPTH_W-1:0] estimate_depth;
    logic [DEPTH_W-1:0] observed_depth;
  } in_item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic                saturated;
  } out_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] est;
    logic [DEPTH_W-1:0] obs;
    logic [COL_W-1:0]   col;
    logic               has_left;
    logic               has_up;
    logic               has_ur;
    logic               frame_end;
  } q_entry_t;

  typedef struct packed {
    logic               vld;
    logic               is_data;
    logic [DEPTH_W-1:0] diff;
  } term_t;

  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } energy_status_t;

endpackage

/* design/mrfde_queue.sv */
// Short FIFO of classified pixels between the front and the back.
// Depends on mrfde_pkg for the entry type and depth.
module mrfde_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mrfde_pkg::q_entry_t push_data,
  input  logic                pop,
  output mrfde_pkg::q_entry_t pop_data,
  output logic                full,
  output logic                empty
);

  mrfde_pkg::q_entry_t entries_r [mrfde_pkg::Q_DEPTH];
  logic [mrfde_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mrfde_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mrfde_pkg::Q_PTR_W:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (mrfde_pkg::Q_PTR_W+1)'(mrfde_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/mrfde_front.sv */
// Input side: raster position counters and neighbor classification of each pixel.
// Depends on mrfde_pkg; feeds mrfde_queue.
module mrfde_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  mrfde_pkg::in_item_t                 in_data,
  output logic                                in_stall,
  input  logic [mrfde_pkg::SIZE_W-1:0]        frame_width,
  input  logic [mrfde_pkg::SIZE_W-1:0]        frame_height,
  input  logic                                q_full,
  output logic                                push,
  output mrfde_pkg::q_entry_t                 entry
);

  logic [mrfde_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [mrfde_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [mrfde_pkg::SIZE_W-1:0] w_eff, h_eff, col_inc, row_inc;
  logic                         last_col, last_row;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = mrfde_pkg::SIZE_W'(1);
    end else if (frame_width > mrfde_pkg::SIZE_W'(mrfde_pkg::MAX_WIDTH)) begin
      w_eff = mrfde_pkg::SIZE_W'(mrfde_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = mrfde_pkg::SIZE_W'(1);
    end else if (frame_height > mrfde_pkg::SIZE_W'(mrfde_pkg::MAX_HEIGHT)) begin
      h_eff = mrfde_pkg::SIZE_W'(mrfde_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign col_inc  = mrfde_pkg::SIZE_W'(col_r) + 1'b1;
  assign row_inc  = mrfde_pkg::SIZE_W'(row_r) + 1'b1;
  assign last_col = (col_inc >= w_eff);
  assign last_row = (row_inc >= h_eff);

  always_comb begin
    entry.est       = in_data.estimate_depth;
    entry.obs       = in_data.observed_depth;
    entry.col       = col_r;
    entry.has_left  = (col_r != '0);
    entry.has_up    = (row_r != '0);
    entry.has_ur    = (row_r != '0) && (col_inc < w_eff)
                      && (col_inc < mrfde_pkg::SIZE_W'(mrfde_pkg::MAX_WIDTH));
    entry.frame_end = last_col && last_row;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* design/mrfde_back.sv */
// Back-end sequencer: line store reads and writes, then one energy term issued per cycle.
// Depends on mrfde_pkg; drains mrfde_queue and drives mrfde_energy.
module mrfde_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  mrfde_pkg::q_entry_t       q_data,
  output logic                      q_pop,
  output mrfde_pkg::term_t          term,
  output logic                      emit,
  input  mrfde_pkg::energy_status_t st
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD0   = 3'd1;
  localparam logic [2:0] ST_RD0W  = 3'd2;
  localparam logic [2:0] ST_RDUR  = 3'd3;
  localparam logic [2:0] ST_ISSUE = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  localparam logic [2:0] TERM_DATA = 3'd0;
  localparam logic [2:0] TERM_LEFT = 3'd1;
  localparam logic [2:0] TERM_UP   = 3'd2;
  localparam logic [2:0] TERM_UL   = 3'd3;
  localparam logic [2:0] TERM_UR   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] k_r, k_nxt;

  mrfde_pkg::q_entry_t                 ent_r;
  logic [mrfde_pkg::DEPTH_W-1:0]       above_r, upleft_r, left_r;
  logic [mrfde_pkg::DEPTH_W-1:0]       row_mem [mrfde_pkg::MAX_WIDTH];
  logic [mrfde_pkg::DEPTH_W-1:0]       rd_data_r;
  logic                                rd_en, wr_en;
  logic [mrfde_pkg::COL_W-1:0]         rd_addr;

  logic                                term_vld_r;
  logic                                term_data_r;
  logic [mrfde_pkg::DEPTH_W-1:0]       term_diff_r;
  logic                                issue_en;
  logic [mrfde_pkg::DEPTH_W-1:0]       operand, diff;

  assign q_pop = (state_r == ST_IDLE) && !q_empty;
  assign emit  = (state_r == ST_FLUSH) && !term_vld_r && st.pipe_empty && st.out_free;

  assign term.vld     = term_vld_r;
  assign term.is_data = term_data_r;
  assign term.diff    = term_diff_r;

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = ent_r.col + 1'b1;
    if (state_r == ST_RD0) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (state_r == ST_RDUR) begin
      rd_en = 1'b1;
      wr_en = 1'b1;
    end
  end

  always_comb begin
    operand  = ent_r.obs;
    issue_en = 1'b0;
    case (k_r)
      TERM_DATA: begin
        operand  = ent_r.obs;
        issue_en = (ent_r.obs != '0);
      end
      TERM_LEFT: begin
        operand  = left_r;
        issue_en = ent_r.has_left;
      end
      TERM_UP: begin
        operand  = above_r;
        issue_en = ent_r.has_up;
      end
      TERM_UL: begin
        operand  = upleft_r;
        issue_en = ent_r.has_up && ent_r.has_left;
      end
      TERM_UR: begin
        operand  = rd_data_r;
        issue_en = ent_r.has_ur;
      end
      default: begin
        operand  = ent_r.obs;
        issue_en = 1'b0;
      end
    endcase
    diff = (ent_r.est >= operand) ? ent_r.est - operand : operand - ent_r.est;
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_data.col == '0) ? ST_RD0 : ST_RDUR;
        end
      end
      ST_RD0: begin
        state_nxt = ST_RD0W;
      end
      ST_RD0W: begin
        state_nxt = ST_RDUR;
      end
      ST_RDUR: begin
        state_nxt = ST_ISSUE;
        k_nxt     = TERM_DATA;
      end
      ST_ISSUE: begin
        if (k_r == TERM_UR) begin
          state_nxt = ent_r.frame_end ? ST_FLUSH : ST_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      k_r        <= TERM_DATA;
      term_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      term_vld_r <= (state_r == ST_ISSUE) && issue_en;
    end
  end

  always_ff @(posedge clk) begin
    term_data_r <= (k_r == TERM_DATA);
    term_diff_r <= diff;
    if (q_pop) begin
      ent_r    <= q_data;
      left_r   <= ent_r.est;
      upleft_r <= above_r;
      above_r  <= rd_data_r;
    end else if (state_r == ST_RD0W) begin
      above_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[ent_r.col] <= ent_r.est;
    end
    if (rd_en) begin
      rd_data_r <= row_mem[rd_addr];
    end
  end

endmodule

/* design/mrfde_energy.sv */
// Term datapath: square, weight or double, saturating frame sum and result register.
// Depends on mrfde_pkg; fed by mrfde_back.
module mrfde_energy (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mrfde_pkg::term_t                term,
  input  logic                            emit,
  input  logic [mrfde_pkg::WEIGHT_W-1:0]  data_weight,
  output mrfde_pkg::energy_status_t       st,
  output logic                            out_valid,
  output mrfde_pkg::out_item_t            out_data,
  input  logic                            out_stall
);

  logic                              b_vld_r, b_data_r;
  logic [mrfde_pkg::SQ_W-1:0]        b_sq_r;
  logic                              c_vld_r;
  logic [mrfde_pkg::TERM_W-1:0]      c_term_r;
  logic [mrfde_pkg::PROD_W-1:0]      prod;
  logic [mrfde_pkg::ENERGY_W:0]      total;
  logic [mrfde_pkg::ENERGY_W-1:0]    sum_r, sum_nxt;
  logic                              sat_r, sat_nxt;
  logic                              out_valid_r, out_valid_nxt;
  mrfde_pkg::out_item_t              out_data_r;

  assign st.pipe_empty = !b_vld_r && !c_vld_r;
  assign st.out_free   = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  assign prod  = mrfde_pkg::PROD_W'(data_weight) * mrfde_pkg::PROD_W'(b_sq_r);
  assign total = (mrfde_pkg::ENERGY_W+1)'(sum_r) + (mrfde_pkg::ENERGY_W+1)'(c_term_r);

  always_comb begin
    sum_nxt       = sum_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      sum_nxt       = '0;
      sat_nxt       = 1'b0;
      out_valid_nxt = 1'b1;
    end else if (c_vld_r) begin
      if (total[mrfde_pkg::ENERGY_W]) begin
        sum_nxt = mrfde_pkg::ENERGY_MAX;
        sat_nxt = 1'b1;
      end else begin
        sum_nxt = total[mrfde_pkg::ENERGY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      sum_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_vld_r     <= term.vld;
      c_vld_r     <= b_vld_r;
      sum_r       <= sum_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_data_r <= term.is_data;
    b_sq_r   <= mrfde_pkg::SQ_W'(term.diff) * mrfde_pkg::SQ_W'(term.diff);
    if (b_data_r) begin
      c_term_r <= mrfde_pkg::TERM_W'(prod >> 8);
    end else begin
      c_term_r <= mrfde_pkg::TERM_W'({b_sq_r, 1'b0});
    end
    if (emit) begin
      out_data_r.energy    <= sum_r;
      out_data_r.saturated <= sat_r;
    end
  end

endmodule

/* design/mrf_depth_energy_accumulator.sv */
// Top level of the MRF depth energy accumulator: config registers, front, queue, back, datapath.
// Depends on mrfde_pkg, mrfde_front, mrfde_queue, mrfde_back and mrfde_energy.
//
// Pixels enter in raster order and are queued (four deep) with their frame position. The back
// end takes one pixel at a time; its pace is set by the single read port of the line store (one
// extra read of column 0 at row start) and by the five energy terms going one per cycle through
// the shared square and weight unit. The frame total leaves once the last pixel's terms have
// drained from the datapath and the result register is free. Energy saturates at 2^63-1 with a
// flag. Configuration writes are accepted every cycle (cfg_ready is always high).
module mrf_depth_energy_accumulator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mrfde_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mrfde_pkg::out_item_t              out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mrfde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrfde_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [mrfde_pkg::SIZE_W-1:0]   frame_width_r, frame_height_r;
  logic [mrfde_pkg::WEIGHT_W-1:0] data_weight_r;

  logic                      push, q_full, q_empty, q_pop, emit;
  mrfde_pkg::q_entry_t       push_entry, pop_entry;
  mrfde_pkg::term_t          term;
  mrfde_pkg::energy_status_t st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= mrfde_pkg::SIZE_W'(882);
      frame_height_r <= mrfde_pkg::SIZE_W'(560);
      data_weight_r  <= mrfde_pkg::WEIGHT_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrfde_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[mrfde_pkg::SIZE_W-1:0];
        mrfde_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[mrfde_pkg::SIZE_W-1:0];
        mrfde_pkg::CFG_DATA_WEIGHT:  data_weight_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mrfde_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .in_stall     (in_stall),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_full       (q_full),
    .push         (push),
    .entry        (push_entry)
  );

  mrfde_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .full      (q_full),
    .empty     (q_empty)
  );

  mrfde_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (pop_entry),
    .q_pop   (q_pop),
    .term    (term),
    .emit    (emit),
    .st      (st)
  );

  mrfde_energy u_energy (
    .clk         (clk),
    .rst_n       (rst_n),
    .term        (term),
    .emit        (emit),
    .data_weight (data_weight_r),
    .st          (st),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty pixel queue");

  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!term.vld && st.pipe_empty && st.out_free))
    else $error("frame result emitted with terms in flight");

  a_sat_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |-> (out_data.energy == mrfde_pkg::ENERGY_MAX))
    else $error("saturated result below maximum");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid)
    else $error("emitted result not presented");

endmodule

/* tb/tb_mrf_depth_energy_accumulator.sv */
// Testbench for mrf_depth_energy_accumulator: streams depth frames and checks every frame energy.
// A scoreboard class predicts the totals pixel by pixel; depends on mrfde_pkg and the block's RTL.
module tb_mrf_depth_energy_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ENERGY_CAP    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          SETTLE_CYCLES = 100;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          MIN_PIXELS    = 1800;
  localparam int          MIN_FRAMES    = 75;

  class frame_energy_model;
    logic [mrfde_pkg::DEPTH_W-1:0] line_depth [mrfde_pkg::MAX_WIDTH];
    logic [mrfde_pkg::DEPTH_W-1:0] left_px;
    logic [mrfde_pkg::DEPTH_W-1:0] up_left_px;
    int unsigned                   col_pos;
    int unsigned                   row_pos;
    logic [63:0]                   frame_sum;
    logic                          frame_sat;
    int unsigned                   width_reg;
    int unsigned                   height_reg;
    int unsigned                   weight_reg;
    mrfde_pkg::out_item_t          expected_totals [$];
    int unsigned                   mismatches;

    function new();
      foreach (line_depth[i]) line_depth[i] = '0;
      left_px    = '0;
      up_left_px = '0;
      col_pos    = 0;
      row_pos    = 0;
      frame_sum  = '0;
      frame_sat  = 1'b0;
      width_reg  = 882;
      height_reg = 560;
      weight_reg = 256;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function void write_reg(logic [mrfde_pkg::CFG_IDX_W-1:0] idx,
                            logic [mrfde_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mrfde_pkg::CFG_FRAME_WIDTH: begin
          width_reg = data[mrfde_pkg::SIZE_W-1:0];
        end
        mrfde_pkg::CFG_FRAME_HEIGHT: begin
          height_reg = data[mrfde_pkg::SIZE_W-1:0];
        end
        mrfde_pkg::CFG_DATA_WEIGHT: begin
          weight_reg = data;
        end
        default: begin
        end
      endcase
    endfunction

    function logic [63:0] sq_diff(logic [mrfde_pkg::DEPTH_W-1:0] a,
                                  logic [mrfde_pkg::DEPTH_W-1:0] b);
      logic [63:0] d;
      d = (a >= b) ? 64'(a - b) : 64'(b - a);
      return d * d;
    endfunction

    function void add_term(logic [63:0] term);
      if (frame_sum > ENERGY_CAP - term) begin
        frame_sum = ENERGY_CAP;
        frame_sat = 1'b1;
      end else begin
        frame_sum = frame_sum + term;
      end
    endfunction

    function void note_pixel(mrfde_pkg::in_item_t px);
      int unsigned                   w;
      int unsigned                   h;
      int unsigned                   col;
      logic [mrfde_pkg::DEPTH_W-1:0] est;
      logic [mrfde_pkg::DEPTH_W-1:0] obs;
      logic [mrfde_pkg::DEPTH_W-1:0] above;
      mrfde_pkg::out_item_t          total;
      w     = clamp_dim(width_reg, mrfde_pkg::MAX_WIDTH);
      h     = clamp_dim(height_reg, mrfde_pkg::MAX_HEIGHT);
      est   = px.estimate_depth;
      obs   = px.observed_depth;
      col   = col_pos;
      above = '0;
      if (obs != '0) add_term((64'(weight_reg) * sq_diff(est, obs)) >> 8);
      if (col > 0) add_term(sq_diff(est, left_px) << 1);
      if (row_pos > 0) begin
        if (col < mrfde_pkg::MAX_WIDTH) above = line_depth[col];
        add_term(sq_diff(est, above) << 1);
        if (col > 0) add_term(sq_diff(est, up_left_px) << 1);
        if (col + 1 < w && col + 1 < mrfde_pkg::MAX_WIDTH) begin
          add_term(sq_diff(est, line_depth[col + 1]) << 1);
        end
      end
      up_left_px = above;
      if (col < mrfde_pkg::MAX_WIDTH) line_depth[col] = est;
      left_px = est;
      if (col + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= h) begin
          total.energy    = frame_sum[mrfde_pkg::ENERGY_W-1:0];
          total.saturated = frame_sat;
          expected_totals.push_back(total);
          row_pos   = 0;
          frame_sum = '0;
          frame_sat = 1'b0;
        end else begin
          row_pos = row_pos + 1;
        end
      end else begin
        col_pos = col + 1;
      end
    endfunction

    function void check_total(mrfde_pkg::out_item_t got);
      mrfde_pkg::out_item_t want;
      if (expected_totals.size() == 0) begin
        $error("energy: no frame pending, actual %0d", got.energy);
        mismatches++;
        return;
      end
      want = expected_totals.pop_front();
      if (got.energy !== want.energy) begin
        $error("energy: expected %0d, actual %0d", want.energy, got.energy);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  mrfde_pkg::in_item_t              in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  mrfde_pkg::out_item_t             out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [mrfde_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mrfde_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  frame_energy_model                frame_energy = new();
  int                               tx_idle_pct  = 28;
  int                               rx_idle_pct  = 73;
  int                               rx_hold      = 0;
  int unsigned                      px_sent      = 0;
  int unsigned                      cycle_count  = 0;
  logic [mrfde_pkg::DEPTH_W-1:0]    depth_base   = 16'h0400;

  mrf_depth_energy_accumulator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold = rx_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) frame_energy.note_pixel(in_data);
      if (out_valid && !out_stall) frame_energy.check_total(out_data);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_mrf_depth_energy_accumulator: FAIL");
    $finish;
  end

  task automatic send_pixel(input logic [mrfde_pkg::DEPTH_W-1:0] est,
                            input logic [mrfde_pkg::DEPTH_W-1:0] obs);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{estimate_depth: est, observed_depth: obs};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    px_sent++;
  endtask

  task automatic send_random_pixel();
    logic [mrfde_pkg::DEPTH_W-1:0] est;
    logic [mrfde_pkg::DEPTH_W-1:0] obs;
    if ($urandom_range(3) == 0) est = mrfde_pkg::DEPTH_W'($urandom);
    else est = depth_base + mrfde_pkg::DEPTH_W'($urandom_range(64)) - mrfde_pkg::DEPTH_W'(32);
    depth_base = est;
    case ($urandom_range(9))
      0, 1, 2: obs = '0;
      3, 4, 5, 6: obs = est + mrfde_pkg::DEPTH_W'($urandom_range(32)) - mrfde_pkg::DEPTH_W'(16);
      default: obs = mrfde_pkg::DEPTH_W'($urandom);
    endcase
    send_pixel(est, obs);
  endtask

  task automatic write_regs(input logic [mrfde_pkg::CFG_DATA_W-1:0] width_val,
                            input logic [mrfde_pkg::CFG_DATA_W-1:0] height_val,
                            input logic [mrfde_pkg::CFG_DATA_W-1:0] weight_val);
    logic [mrfde_pkg::CFG_DATA_W-1:0] vals [3];
    logic [mrfde_pkg::CFG_IDX_W-1:0]  idxs [3];
    vals = '{width_val, height_val, weight_val};
    idxs = '{mrfde_pkg::CFG_FRAME_WIDTH, mrfde_pkg::CFG_FRAME_HEIGHT,
             mrfde_pkg::CFG_DATA_WEIGHT};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      frame_energy.write_reg(idxs[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // hold off until every pending total is out and the pipeline has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_energy.expected_totals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [mrfde_pkg::CFG_DATA_W-1:0] random_dim();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return mrfde_pkg::CFG_DATA_W'($urandom_range(12, 7));
    return mrfde_pkg::CFG_DATA_W'($urandom_range(6, 1));
  endfunction

  function automatic logic [mrfde_pkg::CFG_DATA_W-1:0] random_weight();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return mrfde_pkg::CFG_DATA_W'($urandom);
  endfunction

  initial begin
    logic [mrfde_pkg::CFG_DATA_W-1:0] width_now;
    logic [mrfde_pkg::CFG_DATA_W-1:0] height_now;
    int unsigned                      frame_idx;
    int unsigned                      pixels;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // upper bits of the width write are dropped by the 11-bit register
    write_regs(16'hF803, 16'd2, 16'd256);
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'h0001);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h0001, 16'h0000);
    send_pixel(16'hFFFF, 16'h8000);
    wait_idle();

    // zero sizes act as one pixel per frame
    write_regs(16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0001);
    send_pixel(16'h0000, 16'hFFFF);
    wait_idle();

    // shrink width and height inside a frame
    write_regs(16'd4, 16'd3, 16'd0);
    repeat (5) send_random_pixel();
    wait_idle();
    write_regs(16'd2, 16'd2, 16'd0);
    send_random_pixel();
    wait_idle();

    // grow width inside a frame over columns already written
    write_regs(16'd2, 16'd3, 16'd256);
    repeat (3) send_random_pixel();
    wait_idle();
    write_regs(16'd4, 16'd1, 16'd256);
    repeat (3) send_random_pixel();
    wait_idle();

    frame_idx  = 0;
    width_now  = '0;
    height_now = '0;
    while (frame_idx < MIN_FRAMES || px_sent < MIN_PIXELS) begin
      if (frame_idx == 25) begin
        tx_idle_pct = 73;
        rx_idle_pct = 28;
      end
      if (frame_idx == 50) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_idle();
        write_regs(16'd1, 16'd1, random_weight());
        rx_hold = 400;
        repeat (32) send_random_pixel();
        wait_idle();
        width_now  = 16'd1;
        height_now = 16'd1;
      end
      if (frame_idx == 5) begin
        width_now  = 16'd2047;
        height_now = 16'd1;
        wait_idle();
        write_regs(width_now, height_now, random_weight());
      end else if (frame_idx == 30) begin
        width_now  = 16'd1;
        height_now = 16'd48;
        wait_idle();
        write_regs(width_now, height_now, random_weight());
      end else if (frame_idx == 0 || frame_idx == 6 || frame_idx == 31 ||
                   $urandom_range(2) == 0) begin
        width_now  = random_dim();
        height_now = random_dim();
        wait_idle();
        write_regs(width_now, height_now, random_weight());
      end
      pixels = frame_energy.clamp_dim(width_now, mrfde_pkg::MAX_WIDTH) *
               frame_energy.clamp_dim(height_now, mrfde_pkg::MAX_HEIGHT);
      repeat (pixels) send_random_pixel();
      frame_idx++;
    end

    wait_idle();
    if (frame_energy.mismatches == 0 && frame_energy.expected_totals.size() == 0) begin
      $display("tb_mrf_depth_energy_accumulator: PASS");
    end else begin
      $display("tb_mrf_depth_energy_accumulator: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/mrfde_pkg.sv
design/mrfde_queue.sv
design/mrfde_front.sv
design/mrfde_back.sv
design/mrfde_energy.sv
design/mrf_depth_energy_accumulator.sv
tb/tb_mrf_depth_energy_accumulator.sv
